// ===== rtl/core/upd_pkg.sv =====
package upd_pkg;

  // Longest decoded path that still counts as well formed is PATH_LIMIT - 1.
  localparam int unsigned PATH_LIMIT = 4096;
  localparam logic [16:0] PATH_LIMIT_W = 17'(PATH_LIMIT);

  // Reset value of the output capacity register.
  localparam logic [15:0] CAPACITY_RESET = 16'd4096;

  // Byte codes the decoder reacts to.
  localparam logic [7:0] CHAR_PERCENT   = 8'h25;
  localparam logic [7:0] CHAR_QUERY     = 8'h3F;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_MIN_PRINT = 8'd32;

  // Item kinds on the input channel.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Position inside a percent escape.
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  // Path status reported on the end result.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_TRAVERSAL = 2'd2
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } upd_in_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       done_res;
    status_t    status;
  } upd_out_t;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_lookup(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      v = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      v = {1'b1, 4'(b - 8'h37)};
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/upd_decode.sv =====
module upd_decode
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  upd_in_t     in_item,
  input  logic [15:0] out_capacity,
  output logic        res_valid,
  output upd_out_t    res_item
);

  esc_phase_t  esc_phase_r, esc_phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [15:0] out_count_r, out_count_nxt;
  logic [1:0]  seg_len_r, seg_len_nxt;
  logic        seg_dots_r, seg_dots_nxt;
  logic        trav_r, trav_nxt;
  logic        err_r, err_nxt;
  logic        query_r, query_nxt;

  logic [4:0]  hex;
  logic        have_char;
  logic [7:0]  dec_char;
  logic        bad_hex;
  logic        reject;
  logic        emit;
  logic [16:0] count_inc;
  logic        seg_is_parent;
  logic        end_malformed;
  logic        byte_live;

  // Shared decode of the current beat.
  always_comb begin
    hex       = hex_lookup(in_item.in_byte);
    byte_live = (in_item.kind == KIND_BYTE) && !err_r && !query_r;
    have_char = 1'b0;
    dec_char  = in_item.in_byte;
    bad_hex   = 1'b0;
    case (esc_phase_r)
      ESC_IDLE: begin
        have_char = byte_live && (in_item.in_byte != CHAR_PERCENT) &&
                    (in_item.in_byte != CHAR_QUERY);
      end
      ESC_HIGH: begin
        bad_hex = byte_live && !hex[4];
      end
      ESC_LOW: begin
        bad_hex   = byte_live && !hex[4];
        have_char = byte_live && hex[4];
        dec_char  = {high_nibble_r, hex[3:0]};
      end
      default: begin
        bad_hex = byte_live;
      end
    endcase
    count_inc     = {1'b0, out_count_r} + 17'd1;
    reject        = (dec_char < CHAR_MIN_PRINT) || (dec_char == CHAR_BACKSLASH) ||
                    (count_inc >= {1'b0, out_capacity});
    emit          = have_char && !reject;
    seg_is_parent = (seg_len_r == 2'd2) && seg_dots_r;
    end_malformed = err_r || (esc_phase_r != ESC_IDLE) ||
                    ({1'b0, out_count_r} >= PATH_LIMIT_W);
  end

  // Next decoder state.
  always_comb begin
    esc_phase_nxt   = esc_phase_r;
    high_nibble_nxt = high_nibble_r;
    out_count_nxt   = out_count_r;
    seg_len_nxt     = seg_len_r;
    seg_dots_nxt    = seg_dots_r;
    trav_nxt        = trav_r;
    err_nxt         = err_r;
    query_nxt       = query_r;
    if (in_item.kind == KIND_END) begin
      // The end beat closes the path and starts a fresh one.
      esc_phase_nxt   = ESC_IDLE;
      high_nibble_nxt = 4'd0;
      out_count_nxt   = 16'd0;
      seg_len_nxt     = 2'd0;
      seg_dots_nxt    = 1'b1;
      trav_nxt        = 1'b0;
      err_nxt         = 1'b0;
      query_nxt       = 1'b0;
    end else if (byte_live) begin
      case (esc_phase_r)
        ESC_IDLE: begin
          if (in_item.in_byte == CHAR_PERCENT) begin
            esc_phase_nxt = ESC_HIGH;
          end else if (in_item.in_byte == CHAR_QUERY) begin
            query_nxt = 1'b1;
          end
        end
        ESC_HIGH: begin
          if (hex[4]) begin
            high_nibble_nxt = hex[3:0];
            esc_phase_nxt   = ESC_LOW;
          end
        end
        ESC_LOW: begin
          if (hex[4]) begin
            esc_phase_nxt = ESC_IDLE;
          end
        end
        default: begin
          esc_phase_nxt = ESC_IDLE;
        end
      endcase
      if (bad_hex || (have_char && reject)) begin
        err_nxt = 1'b1;
      end
      if (emit) begin
        out_count_nxt = count_inc[15:0];
        if (dec_char == CHAR_SLASH) begin
          trav_nxt     = trav_r || seg_is_parent;
          seg_len_nxt  = 2'd0;
          seg_dots_nxt = 1'b1;
        end else begin
          if (seg_len_r != 2'd3) begin
            seg_len_nxt = seg_len_r + 2'd1;
          end
          seg_dots_nxt = seg_dots_r && (dec_char == CHAR_DOT);
        end
      end
    end
  end

  // Result of the current beat.
  always_comb begin
    res_item = '{has_byte: 1'b0, out_byte: 8'd0, done_res: 1'b0, status: STATUS_OK};
    res_valid = 1'b0;
    if (in_item.kind == KIND_END) begin
      res_valid         = 1'b1;
      res_item.done_res = 1'b1;
      if (end_malformed) begin
        res_item.status = STATUS_MALFORMED;
      end else if (trav_r || seg_is_parent) begin
        res_item.status = STATUS_TRAVERSAL;
      end
    end else if (emit) begin
      res_valid         = 1'b1;
      res_item.has_byte = 1'b1;
      res_item.out_byte = dec_char;
    end
  end

  // Decoder state advances only when a beat is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_phase_r   <= ESC_IDLE;
      high_nibble_r <= 4'd0;
      out_count_r   <= 16'd0;
      seg_len_r     <= 2'd0;
      seg_dots_r    <= 1'b1;
      trav_r        <= 1'b0;
      err_r         <= 1'b0;
      query_r       <= 1'b0;
    end else if (fire) begin
      esc_phase_r   <= esc_phase_nxt;
      high_nibble_r <= high_nibble_nxt;
      out_count_r   <= out_count_nxt;
      seg_len_r     <= seg_len_nxt;
      seg_dots_r    <= seg_dots_nxt;
      trav_r        <= trav_nxt;
      err_r         <= err_nxt;
      query_r       <= query_nxt;
    end
  end

endmodule

// ===== rtl/core/url_path_percent_decoder.sv =====
// A beat in the input register fires once the output register can take its result.
// Throughput: one input beat per cycle while the output is not stalled; the input
// register, the decode logic and the output register form a two-stage pipeline, so
// a new beat enters while a result waits. Beats that produce no result (escape openers,
// bytes after an error or a '?') vanish. Reset (synchronous, rst_n low) empties both
// stages, clears the decode state and sets the output capacity to 4096.
module url_path_percent_decoder
  import upd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  upd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output upd_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        in_valid_r, in_valid_nxt;
  upd_in_t     in_data_r;
  logic        out_valid_r, out_valid_nxt;
  upd_out_t    out_data_r;
  logic [15:0] capacity_r;

  logic        advance;
  logic        fire;
  logic        in_take;
  logic        res_valid;
  upd_out_t    res_item;

  // The output register can take a new result when empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage occupancy.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire && res_valid;
    end
  end

  upd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .in_item      (in_data_r),
    .out_capacity (capacity_r),
    .res_valid    (res_valid),
    .res_item     (res_item)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAPACITY_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (fire && advance) begin
      out_data_r <= res_item;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("input stalled with an empty input stage");

  a_byte_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.has_byte != out_data.done_res))
    else $error("result is neither a single byte nor a single end status");

  a_byte_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.has_byte) |->
      (out_data.out_byte >= CHAR_MIN_PRINT && out_data.out_byte != CHAR_BACKSLASH &&
       out_data.status == STATUS_OK))
    else $error("emitted byte should have been rejected");
`endif

endmodule
